@@ design/xboe_pkg.sv @@
// Package for the x64 binary-op encoder: item types, kind codes, register indexes.
// No dependencies; used by every module of the encoder.
package xboe_pkg;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    localparam logic [7:0] REX_W_BASE = 8'h48;

    typedef enum logic [2:0] {
        KIND_REG_REG = 3'd0,
        KIND_REG_IMM = 3'd1,
        KIND_REG_MEM = 3'd2,
        KIND_MEM_REG = 3'd3,
        KIND_MEM_IMM = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CFG_OPC_MEM_TO_REG = 3'd0,
        CFG_OPC_REG_TO_RM  = 3'd1,
        CFG_OPC_IMM8       = 3'd2,
        CFG_OPC_IMM32      = 3'd3,
        CFG_IMM_EXT        = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         reg_operand;
        logic [3:0]         other_reg;
        logic [3:0]         mem_base;
        logic               has_index;
        logic [3:0]         mem_index;
        logic [1:0]         scale_code;
        logic signed [31:0] displacement;
        logic signed [31:0] imm_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] chunk_bytes;
        logic [3:0]  chunk_len;
        logic        last;
        logic        illegal;
    } out_item_t;

    // encoded instruction word plus the pending immediate, queued front to back
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  len;
        logic        illegal;
        logic        has_imm;
        logic        imm_small;
        logic [31:0] imm;
    } enc_t;

    function automatic logic fits8(input logic [31:0] v);
        fits8 = (v[31:7] == '0) || (&v[31:7]);
    endfunction

endpackage

@@ design/xboe_front.sv @@
// Front end: configuration registers and instruction classification/encoding.
// Depends on xboe_pkg.
module xboe_front
    import xboe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  in_item_t   item,
    output enc_t       enc
);

    logic [7:0] opc_mem_to_reg_reg;
    logic [7:0] opc_reg_to_rm_reg;
    logic [7:0] opc_imm8_reg;
    logic [7:0] opc_imm32_reg;
    logic [2:0] imm_ext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opc_mem_to_reg_reg <= 8'h03;
            opc_reg_to_rm_reg  <= 8'h01;
            opc_imm8_reg       <= 8'h83;
            opc_imm32_reg      <= 8'h81;
            imm_ext_reg        <= 3'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OPC_MEM_TO_REG: opc_mem_to_reg_reg <= cfg_data;
                CFG_OPC_REG_TO_RM:  opc_reg_to_rm_reg  <= cfg_data;
                CFG_OPC_IMM8:       opc_imm8_reg       <= cfg_data;
                CFG_OPC_IMM32:      opc_imm32_reg      <= cfg_data;
                CFG_IMM_EXT:        imm_ext_reg        <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic        is_mem;
        logic        is_imm;
        logic        small_imm;
        logic        valid_kind;
        logic [7:0]  opcode;
        logic [3:0]  regfield;
        logic [7:0]  rex;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic        need_disp;
        logic        d8;
        logic [1:0]  mode;
        logic [31:0] dval;
        logic [3:0]  dlen;
        logic        mem_bad;

        is_mem     = 1'b0;
        is_imm     = 1'b0;
        valid_kind = 1'b1;
        small_imm  = fits8(item.imm_value);
        opcode     = opc_reg_to_rm_reg;
        regfield   = item.other_reg;
        rex        = '0;
        modrm      = '0;

        unique case (item.kind)
            KIND_REG_REG: ;
            KIND_REG_IMM:
            begin
                is_imm   = 1'b1;
                opcode   = small_imm ? opc_imm8_reg : opc_imm32_reg;
                regfield = {1'b0, imm_ext_reg};
            end
            KIND_REG_MEM:
            begin
                is_mem   = 1'b1;
                opcode   = opc_mem_to_reg_reg;
                regfield = item.reg_operand;
            end
            KIND_MEM_REG:
            begin
                is_mem   = 1'b1;
                regfield = item.reg_operand;
            end
            KIND_MEM_IMM:
            begin
                is_mem   = 1'b1;
                is_imm   = 1'b1;
                opcode   = small_imm ? opc_imm8_reg : opc_imm32_reg;
                regfield = {1'b0, imm_ext_reg};
            end
            default: valid_kind = 1'b0;
        endcase

        need_disp = (item.displacement != '0) || (item.mem_base[2:0] == 3'd5);
        d8        = fits8(item.displacement);
        mode      = need_disp ? (d8 ? 2'd1 : 2'd2) : 2'd0;
        dlen      = need_disp ? (d8 ? 4'd1 : 4'd4) : 4'd0;
        dval      = need_disp ? (d8 ? {24'd0, item.displacement[7:0]} : item.displacement)
                              : 32'd0;
        mem_bad   = item.has_index ? (item.mem_index == 4'd4) : (item.mem_base[2:0] == 3'd4);
        sib       = {item.scale_code, item.mem_index[2:0], item.mem_base[2:0]};

        enc.imm       = item.imm_value;
        enc.imm_small = small_imm;
        enc.has_imm   = is_imm;
        enc.illegal   = 1'b0;

        if (!valid_kind || (is_mem && mem_bad))
        begin
            enc.word    = '0;
            enc.len     = 4'd0;
            enc.illegal = 1'b1;
            enc.has_imm = 1'b0;
        end
        else if (!is_mem)
        begin
            rex      = REX_W_BASE | {5'd0, regfield[3], 1'b0, item.reg_operand[3]};
            modrm    = {2'b11, regfield[2:0], item.reg_operand[2:0]};
            enc.word = {40'd0, modrm, opcode, rex};
            enc.len  = 4'd3;
        end
        else
        begin
            rex = REX_W_BASE | {5'd0, regfield[3], item.has_index & item.mem_index[3],
                                item.mem_base[3]};
            if (item.has_index)
            begin
                modrm    = {mode, regfield[2:0], 3'd4};
                enc.word = {dval, sib, modrm, opcode, rex};
                enc.len  = 4'd4 + dlen;
            end
            else
            begin
                modrm    = {mode, regfield[2:0], item.mem_base[2:0]};
                enc.word = {8'd0, dval, modrm, opcode, rex};
                enc.len  = 4'd3 + dlen;
            end
        end
    end

endmodule

@@ design/xboe_queue.sv @@
// Short queue of encoded items between front and back end.
// Depends on xboe_pkg.
module xboe_queue
    import xboe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  enc_t wr_data,
    output logic full,
    input  logic rd_en,
    output enc_t rd_data,
    output logic empty
);

    enc_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/xboe_back.sv @@
// Back end: emits instruction word chunk then optional immediate chunk.
// Depends on xboe_pkg.
module xboe_back
    import xboe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  enc_t      q_data,
    input  logic      q_empty,
    output logic      q_pop,
    output out_item_t result,
    output logic      empty,
    input  logic      pop
);

    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t pend_reg;
    out_item_t pend_next;
    logic      pend_valid_reg;
    logic      pend_valid_next;
    logic      out_free;

    assign out_free = !out_valid_reg || pop;
    assign result   = out_reg;
    assign empty    = !out_valid_reg;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pop;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        q_pop           = 1'b0;

        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                q_pop                = 1'b1;
                out_valid_next       = 1'b1;
                out_next.chunk_bytes = q_data.word;
                out_next.chunk_len   = q_data.len;
                out_next.last        = !q_data.has_imm;
                out_next.illegal     = q_data.illegal;
                pend_valid_next      = q_data.has_imm;
                pend_next.chunk_bytes = q_data.imm_small ? {56'd0, q_data.imm[7:0]}
                                                         : {32'd0, q_data.imm};
                pend_next.chunk_len  = q_data.imm_small ? 4'd1 : 4'd4;
                pend_next.last       = 1'b1;
                pend_next.illegal    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("immediate chunk pending without word chunk");

    a_not_last_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> pend_valid_reg)
        else $error("non-final chunk without pending immediate");

    a_illegal_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.illegal) |-> (out_reg.last && out_reg.chunk_len == 4'd0))
        else $error("illegal item not a single empty chunk");

    a_no_pop_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !q_pop)
        else $error("queue popped while immediate chunk pending");

endmodule

@@ design/x64_binary_op_encoder.sv @@
// Top level of the x64 two-operand ALU instruction encoder.
// Depends on xboe_pkg, xboe_front, xboe_queue, xboe_back.
//
// Usage:
//   Input queue port: an item is taken when push is high and full is low.
//   Result queue port: while empty is low the oldest result chunk is on
//   result; it is taken when pop is high and empty is low.
//   Config port: cfg_valid/cfg_ready with cfg_index/cfg_data; cfg_ready is
//   always high. Write only while no item is in flight.
//   Each item yields the instruction word chunk (REX, opcode, ModRM, SIB,
//   displacement) and, for immediate forms, a second chunk with the imm8 or
//   imm32. Illegal operand combinations yield one empty chunk flagged illegal.
//   The first chunk passes through the queue and then the result register.
//   Throughput: the queue takes one item per cycle while full is low;
//   immediate forms yield two chunks, and the single result register drains one chunk per cycle while pop is high.
//   A four-entry queue separates encoding from chunk output, so a stalled
//   receiver fills the queue before full rises; nothing is lost.
//   Reset empties the queue and result register and restores default opcodes.
module x64_binary_op_encoder
    import xboe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    enc_t enc;
    enc_t q_data;
    logic q_empty;
    logic q_pop;

    assign cfg_ready = 1'b1;

    xboe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .enc       (enc)
    );

    xboe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (enc),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    xboe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

@@ bench/x64_binary_op_encoder_tb.sv @@
`timescale 1ns / 100ps
// Testbench for x64_binary_op_encoder: directed and random items over several opcode settings,
// checked chunk by chunk against an encoder model kept in this file. Depends on xboe_pkg.
module x64_binary_op_encoder_tb;
    import xboe_pkg::*;

    localparam logic [3:0] REG_RSP = 4'd4;
    localparam logic [3:0] REG_RBP = 4'd5;
    localparam logic [3:0] REG_R8  = 4'd8;
    localparam logic [3:0] REG_R12 = 4'd12;
    localparam logic [3:0] REG_R13 = 4'd13;
    localparam logic [3:0] REG_R15 = 4'd15;
    localparam int IDLE_PCT  = 22;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 80;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    in_item_t   item = '0;
    logic       empty;
    logic       pop = 1'b0;
    out_item_t  result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    logic [7:0] opc_mem_to_reg = 8'h03;
    logic [7:0] opc_reg_to_rm  = 8'h01;
    logic [7:0] opc_imm8       = 8'h83;
    logic [7:0] opc_imm32      = 8'h81;
    logic [2:0] imm_ext        = 3'd0;

    in_item_t  pending_items[$];
    out_item_t expected_chunks[$];
    out_item_t want;
    bit        steady = 1'b0;
    int        hold_left = 0;
    int        items_sent = 0;
    int        illegal_items = 0;
    int        chunks_seen = 0;
    int        settings_used = 1;
    int        mismatches = 0;

    x64_binary_op_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void add_chunk(logic [63:0] bytes, logic [3:0] len, logic last,
                                      logic ill);
        out_item_t ch;
        ch.chunk_bytes = bytes;
        ch.chunk_len   = len;
        ch.last        = last;
        ch.illegal     = ill;
        expected_chunks.push_back(ch);
    endfunction

    // expected chunks of one instruction under the current opcode settings
    function automatic void encode_instruction(in_item_t it);
        logic        is_mem;
        logic        is_imm;
        logic        small_imm;
        logic        need_disp;
        logic        short_disp;
        logic [7:0]  opc;
        logic [7:0]  rex;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic [3:0]  regf;
        logic [1:0]  mode;
        logic [63:0] word;
        int          len;
        int          dlen;
        if (it.kind > KIND_MEM_IMM)
        begin
            illegal_items++;
            add_chunk('0, 4'd0, 1'b1, 1'b1);
            return;
        end
        is_mem = (it.kind == KIND_REG_MEM) || (it.kind == KIND_MEM_REG)
                 || (it.kind == KIND_MEM_IMM);
        is_imm = (it.kind == KIND_REG_IMM) || (it.kind == KIND_MEM_IMM);
        small_imm = (it.imm_value >= -128) && (it.imm_value <= 127);
        if (is_imm)
        begin
            opc  = small_imm ? opc_imm8 : opc_imm32;
            regf = {1'b0, imm_ext};
        end
        else if (it.kind == KIND_REG_MEM)
        begin
            opc  = opc_mem_to_reg;
            regf = it.reg_operand;
        end
        else if (it.kind == KIND_MEM_REG)
        begin
            opc  = opc_reg_to_rm;
            regf = it.reg_operand;
        end
        else
        begin
            opc  = opc_reg_to_rm;
            regf = it.other_reg;
        end
        if (!is_mem)
        begin
            rex   = REX_W_BASE | {5'b0, regf[3], 1'b0, it.reg_operand[3]};
            modrm = {2'b11, regf[2:0], it.reg_operand[2:0]};
            word  = {40'b0, modrm, opc, rex};
            len   = 3;
        end
        else
        begin
            if (it.has_index ? (it.mem_index == REG_RSP) : (it.mem_base[2:0] == REG_RSP[2:0]))
            begin
                illegal_items++;
                add_chunk('0, 4'd0, 1'b1, 1'b1);
                return;
            end
            need_disp  = (it.displacement != 0) || (it.mem_base[2:0] == REG_RBP[2:0]);
            short_disp = (it.displacement >= -128) && (it.displacement <= 127);
            mode = !need_disp ? 2'd0 : (short_disp ? 2'd1 : 2'd2);
            dlen = !need_disp ? 0 : (short_disp ? 1 : 4);
            rex  = REX_W_BASE | {5'b0, regf[3], it.has_index & it.mem_index[3],
                                 it.mem_base[3]};
            if (it.has_index)
            begin
                modrm = {mode, regf[2:0], REG_RSP[2:0]};
                sib   = {it.scale_code, it.mem_index[2:0], it.mem_base[2:0]};
                word  = {32'b0, sib, modrm, opc, rex};
                len   = 4;
            end
            else
            begin
                modrm = {mode, regf[2:0], it.mem_base[2:0]};
                word  = {40'b0, modrm, opc, rex};
                len   = 3;
            end
            if (dlen == 1)
                word |= {56'b0, it.displacement[7:0]} << (8 * len);
            else if (dlen == 4)
                word |= {32'b0, it.displacement} << (8 * len);
            len += dlen;
        end
        add_chunk(word, 4'(len), !is_imm, 1'b0);
        if (is_imm)
        begin
            if (small_imm)
                add_chunk({56'b0, it.imm_value[7:0]}, 4'd1, 1'b1, 1'b0);
            else
                add_chunk({32'b0, it.imm_value}, 4'd4, 1'b1, 1'b0);
        end
    endfunction

    function automatic in_item_t mk(logic [2:0] kind, logic [3:0] regop, logic [3:0] other,
                                    logic [3:0] base, logic hidx, logic [3:0] idx,
                                    logic [1:0] scale, logic [31:0] disp, logic [31:0] imm);
        in_item_t it;
        it.kind         = kind;
        it.reg_operand  = regop;
        it.other_reg    = other;
        it.mem_base     = base;
        it.has_index    = hidx;
        it.mem_index    = idx;
        it.scale_code   = scale;
        it.displacement = disp;
        it.imm_value    = imm;
        return it;
    endfunction

    // zero, short, edges of the short range, or anything
    function automatic logic [31:0] random_word();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'($urandom_range(255)) - 32'd128;
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h0000_007F;
                    1: return 32'h0000_0080;
                    2: return 32'hFFFF_FF80;
                    default: return 32'hFFFF_FF7F;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic in_item_t random_item();
        logic [2:0] kind;
        if ($urandom_range(99) < 5)
            kind = 3'($urandom_range(5, 7));
        else
            kind = 3'($urandom_range(int'(KIND_REG_REG), int'(KIND_MEM_IMM)));
        return mk(kind, 4'($urandom), 4'($urandom), 4'($urandom), 1'($urandom),
                  4'($urandom), 2'($urandom), random_word(), random_word());
    endfunction

    // sender: takes pending items in order, idling at random except in steady phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                encode_instruction(item);
                items_sent++;
            end
            if (!push || !full)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    item <= pending_items.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // receiver: checks each chunk, stalls at random outside steady phases and once for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chunks.size() == 0)
                begin
                    $error("chunk with nothing expected: chunk_bytes %h", result.chunk_bytes);
                    mismatches++;
                end
                else
                begin
                    want = expected_chunks.pop_front();
                    if (result.chunk_bytes !== want.chunk_bytes)
                    begin
                        $error("chunk_bytes: expected %h, got %h", want.chunk_bytes,
                               result.chunk_bytes);
                        mismatches++;
                    end
                    if (result.chunk_len !== want.chunk_len)
                    begin
                        $error("chunk_len: expected %0d, got %0d", want.chunk_len,
                               result.chunk_len);
                        mismatches++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, result.last);
                        mismatches++;
                    end
                    if (result.illegal !== want.illegal)
                    begin
                        $error("illegal: expected %b, got %b", want.illegal, result.illegal);
                        mismatches++;
                    end
                end
                chunks_seen++;
                if (chunks_seen == HOLD_AT)
                    hold_left = HOLD_LEN;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic wait_idle(int tail);
        while (pending_items.size() != 0 || push || expected_chunks.size() != 0)
            @(negedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic set_opcodes(logic [7:0] m2r, logic [7:0] r2rm, logic [7:0] i8,
                               logic [7:0] i32, logic [2:0] ext);
        logic [7:0] vals[5];
        vals = '{m2r, r2rm, i8, i32, {5'b0, ext}};
        for (int i = 0; i < 5; i++)
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (cfg_index_t'(i))
                CFG_OPC_MEM_TO_REG: opc_mem_to_reg = vals[i];
                CFG_OPC_REG_TO_RM:  opc_reg_to_rm  = vals[i];
                CFG_OPC_IMM8:       opc_imm8       = vals[i];
                CFG_OPC_IMM32:      opc_imm32      = vals[i];
                CFG_IMM_EXT:        imm_ext        = vals[i][2:0];
                default: ;
            endcase
            cfg_valid <= 1'b0;
        end
        settings_used++;
    endtask

    task automatic run_phase(int n_random, bit no_idle);
        @(negedge clk);
        steady = no_idle;
        pending_items.push_back(mk(KIND_REG_REG, 4'd0, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0, 0));
        pending_items.push_back(mk(KIND_REG_REG, REG_R15, REG_R15, '1, 1'b1, '1, 2'd3, '1, '1));
        pending_items.push_back(mk(KIND_REG_REG, REG_R8, REG_RSP, 4'd0, 1'b0, 4'd0, 2'd0, 0, 0));
        pending_items.push_back(mk(KIND_REG_IMM, 4'd0, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0, 0));
        pending_items.push_back(mk(KIND_REG_IMM, REG_R8, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0, 127));
        pending_items.push_back(mk(KIND_REG_IMM, 4'd3, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0, -128));
        pending_items.push_back(mk(KIND_REG_IMM, 4'd1, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0, 128));
        pending_items.push_back(mk(KIND_REG_IMM, 4'd2, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0, -129));
        pending_items.push_back(mk(KIND_REG_IMM, 4'd7, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0,
                                   32'h7FFF_FFFF));
        pending_items.push_back(mk(KIND_REG_IMM, REG_R15, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0,
                                   32'h8000_0000));
        pending_items.push_back(mk(KIND_REG_MEM, 4'd0, 4'd0, 4'd0, 1'b0, 4'd0, 2'd0, 0, 0));
        pending_items.push_back(mk(KIND_REG_MEM, 4'd1, 4'd0, REG_RBP, 1'b0, 4'd0, 2'd0, 0, 0));
        pending_items.push_back(mk(KIND_REG_MEM, REG_R12, 4'd0, REG_R13, 1'b0, 4'd0, 2'd0, 0, 0));
        pending_items.push_back(mk(KIND_REG_MEM, 4'd0, 4'd0, REG_RSP, 1'b0, 4'd0, 2'd0, 8, 0));
        pending_items.push_back(mk(KIND_MEM_REG, 4'd2, 4'd0, REG_R12, 1'b0, 4'd0, 2'd0, 0, 0));
        pending_items.push_back(mk(KIND_MEM_REG, 4'd2, 4'd0, 4'd3, 1'b1, REG_RSP, 2'd1, 4, 0));
        pending_items.push_back(mk(KIND_REG_MEM, 4'd9, 4'd0, REG_RSP, 1'b1, REG_R12, 2'd3,
                                   -128, 0));
        pending_items.push_back(mk(KIND_MEM_REG, REG_R15, 4'd0, REG_R15, 1'b1, REG_R15, 2'd2,
                                   127, 0));
        pending_items.push_back(mk(KIND_MEM_REG, 4'd6, 4'd0, 4'd6, 1'b0, 4'd0, 2'd0, 128, 0));
        pending_items.push_back(mk(KIND_REG_MEM, 4'd5, 4'd0, REG_R8, 1'b1, 4'd0, 2'd0, -129, 0));
        pending_items.push_back(mk(KIND_MEM_REG, 4'd4, 4'd0, 4'd1, 1'b0, 4'd0, 2'd0,
                                   32'h8000_0000, 0));
        pending_items.push_back(mk(KIND_MEM_IMM, 4'd0, 4'd0, REG_RBP, 1'b1, REG_R8, 2'd1,
                                   32'h7FFF_FFFF, -1));
        pending_items.push_back(mk(KIND_MEM_IMM, 4'd0, 4'd0, REG_R13, 1'b0, 4'd0, 2'd0, 0,
                                   32'h1234_5678));
        for (int k = int'(KIND_MEM_IMM) + 1; k < 8; k++)
            pending_items.push_back(mk(3'(k), '1, '1, '1, 1'b1, '1, 2'd3, '1, '1));
        for (int n = 0; n < n_random; n++)
            pending_items.push_back(random_item());
        wait_idle(4);
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_phase(350, 1'b0);
        set_opcodes(8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
        run_phase(300, 1'b0);
        set_opcodes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
        run_phase(300, 1'b0);
        set_opcodes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
        run_phase(400, 1'b1);
        set_opcodes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
        run_phase(300, 1'b0);
        set_opcodes(8'h03, 8'h01, 8'h83, 8'h81, 3'd0);
        run_phase(300, 1'b0);
        wait_idle(10);
        $display("Encoded %0d items (%0d illegal) into %0d chunks over %0d opcode settings,",
                 items_sent, illegal_items, chunks_seen, settings_used);
        $display("with a directed sweep per setting, random stalls and one long receiver stall.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $error("run timed out with %0d chunks still expected", expected_chunks.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
